FILE: sv/dstq_pkg.sv
package dstq_pkg;
    localparam int DEF_CAPACITY = 64;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_TICK   = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_FULL     = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_BAD      = 3'd3,
        ST_DISPATCH = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_RESULT,
        FSM_DRAIN
    } fsm_t;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic        ins;    // insert new entry
        logic        del;    // remove entry matching key_slot
        logic        pop;    // shift whole chain toward head by one
        logic [31:0] due;
        logic [31:0] tag;
        logic [31:0] arg;
        logic [7:0]  key_slot;
    } cell_cmd_t;
endpackage

FILE: sv/dstq_if.sv
interface dstq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] delay;
    logic [31:0] task_tag;
    logic [31:0] task_arg;
    logic [5:0]  handle;
    modport source (output valid, command, delay, task_tag, task_arg, handle, input ready);
    modport sink   (input valid, command, delay, task_tag, task_arg, handle, output ready);
endinterface

interface dstq_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [31:0] out_tag;
    logic [31:0] out_arg;
    logic        last;
    modport source (output valid, status, slot, out_tag, out_arg, last, input ready);
    modport sink   (input valid, status, slot, out_tag, out_arg, last, output ready);
endinterface

FILE: sv/dstq_cell.sv
// One list position. Cells form an ordered chain; position 0 is the head.
module dstq_cell
    import dstq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_cmd_t   cmd,
    // neighbor toward head (i-1)
    input  logic        prev_valid,
    input  logic        prev_goes_after,
    input  logic [31:0] prev_due,
    input  logic [31:0] prev_tag,
    input  logic [31:0] prev_arg,
    input  logic [7:0]  prev_slot,
    input  logic        prev_del_seen,
    // neighbor toward tail (i+1)
    input  logic        nxt_valid,
    input  logic [31:0] nxt_due,
    input  logic [31:0] nxt_tag,
    input  logic [31:0] nxt_arg,
    input  logic [7:0]  nxt_slot,
    output logic        valid,
    output logic        goes_after,
    output logic        del_seen,
    output logic [31:0] due,
    output logic [31:0] tag,
    output logic [31:0] arg,
    output logic [7:0]  slot
);
    logic        valid_reg, valid_next;
    logic [31:0] due_reg, due_next, tag_reg, tag_next, arg_reg, arg_next;
    logic [7:0]  slot_reg, slot_next;

    // new entry belongs behind this one
    assign goes_after = valid_reg && (cmd.due >= due_reg);
    assign del_seen   = prev_del_seen || (valid_reg && slot_reg == cmd.key_slot);

    always_comb
    begin
        valid_next = valid_reg;
        due_next   = due_reg;
        tag_next   = tag_reg;
        arg_next   = arg_reg;
        slot_next  = slot_reg;
        if (cmd.pop || (cmd.del && del_seen))
        begin
            valid_next = nxt_valid;
            due_next   = nxt_due;
            tag_next   = nxt_tag;
            arg_next   = nxt_arg;
            slot_next  = nxt_slot;
        end
        else if (cmd.ins && !goes_after)
        begin
            if (prev_goes_after)
            begin
                valid_next = 1'b1;
                due_next   = cmd.due;
                tag_next   = cmd.tag;
                arg_next   = cmd.arg;
                slot_next  = cmd.key_slot;
            end
            else
            begin
                valid_next = prev_valid;
                due_next   = prev_due;
                tag_next   = prev_tag;
                arg_next   = prev_arg;
                slot_next  = prev_slot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        due_reg  <= due_next;
        tag_reg  <= tag_next;
        arg_reg  <= arg_next;
        slot_reg <= slot_next;
    end

    assign valid = valid_reg;
    assign due   = due_reg;
    assign tag   = tag_reg;
    assign arg   = arg_reg;
    assign slot  = slot_reg;
endmodule

FILE: sv/deadline_sorted_timer_queue.sv
// Sorted deadline queue built as a chain of CAPACITY cells kept in due-time
// order (head at cell 0). Add and remove update all cells in parallel when the
// command is taken, then hold their registered result until it is accepted. A
// tick dispatches one due entry per cycle from the head cell while the output
// is not stalled, and returns to idle once the head is no longer due; a tick
// with nothing due gives no output. Free slot lookup uses an occupancy vector
// with a priority encoder. Input is not taken while results are pending.
module deadline_sorted_timer_queue
    import dstq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)(
    input  logic clk,
    input  logic rst_n,
    dstq_in_if.sink    in_ch,
    dstq_out_if.source out_ch
);
    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    fsm_t state_reg, state_next;
    logic [31:0] now_reg, now_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CAPACITY-1:0] occ_reg, occ_next;
    logic [2:0]  st_reg, st_next;
    logic [5:0]  slot_reg, slot_next;
    logic [6:0]  ndisp_reg, ndisp_next;

    cell_cmd_t cmd;
    logic [CAPACITY:0] c_valid;
    logic [CAPACITY-1:0] c_after, c_del;
    logic [31:0] c_due [CAPACITY+1];
    logic [31:0] c_tag [CAPACITY+1];
    logic [31:0] c_arg [CAPACITY+1];
    logic [7:0]  c_slot [CAPACITY+1];

    assign c_valid[CAPACITY] = 1'b0;
    assign c_due[CAPACITY]   = '0;
    assign c_tag[CAPACITY]   = '0;
    assign c_arg[CAPACITY]   = '0;
    assign c_slot[CAPACITY]  = '0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            dstq_cell u_cell (
                .clk(clk), .rst_n(rst_n), .cmd(cmd),
                .prev_valid(g == 0 ? 1'b0 : c_valid[(g == 0) ? 0 : g-1]),
                .prev_goes_after(g == 0 ? 1'b1 : c_after[(g == 0) ? 0 : g-1]),
                .prev_due(c_due[(g == 0) ? 0 : g-1]),
                .prev_tag(c_tag[(g == 0) ? 0 : g-1]),
                .prev_arg(c_arg[(g == 0) ? 0 : g-1]),
                .prev_slot(c_slot[(g == 0) ? 0 : g-1]),
                .prev_del_seen(g == 0 ? 1'b0 : c_del[(g == 0) ? 0 : g-1]),
                .nxt_valid(c_valid[g+1]), .nxt_due(c_due[g+1]),
                .nxt_tag(c_tag[g+1]), .nxt_arg(c_arg[g+1]), .nxt_slot(c_slot[g+1]),
                .valid(c_valid[g]), .goes_after(c_after[g]), .del_seen(c_del[g]),
                .due(c_due[g]), .tag(c_tag[g]), .arg(c_arg[g]), .slot(c_slot[g])
            );
        end
    endgenerate

    // lowest free slot
    logic [SW-1:0] free_slot;
    logic          have_free;
    always_comb
    begin
        free_slot = '0;
        have_free = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!occ_reg[i])
            begin
                free_slot = SW'(i);
                have_free = 1'b1;
            end
        end
    end

    logic in_fire, out_fire, head_due, h_ok;
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign head_due = c_valid[0] && (c_due[0] <= now_reg) && (ndisp_reg < 7'd64);
    assign h_ok     = (CAPACITY >= 64) ? 1'b1 : ({2'b0, in_ch.handle} < 8'(CAPACITY));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
                if (in_fire)
                begin
                    if (in_ch.command == CMD_TICK)
                        state_next = FSM_DRAIN;
                    else if (in_ch.command == CMD_ADD || in_ch.command == CMD_REMOVE)
                        state_next = FSM_RESULT;
                end
            FSM_RESULT:
                if (out_fire)
                    state_next = FSM_IDLE;
            FSM_DRAIN:
                if (!head_due || out_fire)
                    state_next = head_due ? FSM_DRAIN : FSM_IDLE;
            default: state_next = FSM_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.due      = now_reg + in_ch.delay;
        cmd.tag      = in_ch.task_tag;
        cmd.arg      = in_ch.task_arg;
        cmd.key_slot = 8'(free_slot);
        now_next   = now_reg;
        count_next = count_reg;
        occ_next   = occ_reg;
        st_next    = st_reg;
        slot_next  = slot_reg;
        ndisp_next = ndisp_reg;
        if (state_reg == FSM_IDLE && in_fire)
        begin
            unique case (in_ch.command)
                CMD_ADD:
                    if (have_free)
                    begin
                        cmd.ins = 1'b1;
                        occ_next[free_slot] = 1'b1;
                        count_next = count_reg + 1'b1;
                        st_next = ST_ADDED;
                        slot_next = 6'(free_slot);
                    end
                    else
                    begin
                        st_next = ST_FULL;
                        slot_next = '0;
                    end
                CMD_REMOVE:
                begin
                    slot_next = '0;
                    if (h_ok && occ_reg[SW'(in_ch.handle)])
                    begin
                        cmd.del = 1'b1;
                        cmd.key_slot = 8'(in_ch.handle);
                        occ_next[SW'(in_ch.handle)] = 1'b0;
                        count_next = count_reg - 1'b1;
                        st_next = ST_REMOVED;
                    end
                    else
                        st_next = ST_BAD;
                end
                CMD_TICK:
                begin
                    now_next = now_reg + 32'd1;
                    ndisp_next = '0;
                end
                default: ;
            endcase
        end
        else if (state_reg == FSM_DRAIN && head_due && out_fire)
        begin
            cmd.pop = 1'b1;
            occ_next[SW'(c_slot[0])] = 1'b0;
            count_next = count_reg - 1'b1;
            ndisp_next = ndisp_reg + 7'd1;
        end
    end

    // is the entry after the head also due (decides last)
    logic next_due;
    assign next_due = c_valid[1] && (c_due[1] <= now_reg) && (ndisp_reg < 7'd63);

    assign in_ch.ready = (state_reg == FSM_IDLE);
    assign out_ch.valid = (state_reg == FSM_RESULT) || (state_reg == FSM_DRAIN && head_due);
    assign out_ch.status = (state_reg == FSM_DRAIN) ? ST_DISPATCH : st_reg;
    assign out_ch.slot = (state_reg == FSM_DRAIN) ? 6'(c_slot[0]) : slot_reg;
    assign out_ch.out_tag = (state_reg == FSM_DRAIN) ? c_tag[0] : '0;
    assign out_ch.out_arg = (state_reg == FSM_DRAIN) ? c_arg[0] : '0;
    assign out_ch.last = (state_reg == FSM_DRAIN) ? !next_due : 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            now_reg   <= '0;
            count_reg <= '0;
            occ_reg   <= '0;
            ndisp_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            now_reg   <= now_next;
            count_reg <= count_next;
            occ_reg   <= occ_next;
            ndisp_reg <= ndisp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg   <= st_next;
        slot_reg <= slot_next;
    end
endmodule

FILE: sv/dstq_checker.sv
module dstq_checker
    import dstq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [2:0] status,
    input logic [31:0] out_tag,
    input logic last
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken with result pending");
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_DISPATCH) |-> last) else $error("last missing");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(out_tag)))
        else $error("result dropped");
    a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_DISPATCH) |-> out_tag == 32'd0) else $error("tag");
endmodule

bind deadline_sorted_timer_queue dstq_checker u_dstq_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status(out_ch.status), .out_tag(out_ch.out_tag), .last(out_ch.last)
);

FILE: tb/tb_deadline_sorted_timer_queue.sv
module tb_deadline_sorted_timer_queue;
    import dstq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SLOTS      = DEF_CAPACITY;
    localparam int          MAX_BURST  = 64;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [31:0] tag;
        logic [31:0] arg;
        logic        last;
    } timer_event_t;

    class timer_scoreboard;
        logic [31:0]  now_ticks;
        logic [31:0]  due_at [SLOTS];
        logic [31:0]  tag_of [SLOTS];
        logic [31:0]  arg_of [SLOTS];
        bit           busy [SLOTS];
        int           due_order [$];
        timer_event_t pending_events [$];
        int           failures;

        function new();
            now_ticks = '0;
            failures  = 0;
            foreach (busy[i])
                busy[i] = 0;
        endfunction

        function void push_event(status_t st, int s, logic [31:0] t, logic [31:0] a, bit l);
            timer_event_t ev;
            ev.status = st;
            ev.slot   = s[5:0];
            ev.tag    = t;
            ev.arg    = a;
            ev.last   = l;
            pending_events.push_back(ev);
        endfunction

        // predicts the events caused by one accepted command
        function void note_command(logic [1:0] cmd, logic [31:0] delay, logic [31:0] tag,
                                   logic [31:0] arg, logic [5:0] handle);
            int          free_slot;
            int          pos;
            int          n;
            logic [31:0] due;
            if (cmd == CMD_ADD) begin
                if (due_order.size() >= SLOTS) begin
                    push_event(ST_FULL, 0, '0, '0, 1);
                    return;
                end
                free_slot = 0;
                while (busy[free_slot])
                    free_slot++;
                due = now_ticks + delay;
                pos = 0;
                // equal due times keep arrival order
                while (pos < due_order.size() && due >= due_at[due_order[pos]])
                    pos++;
                due_order.insert(pos, free_slot);
                due_at[free_slot] = due;
                tag_of[free_slot] = tag;
                arg_of[free_slot] = arg;
                busy[free_slot]   = 1;
                push_event(ST_ADDED, free_slot, '0, '0, 1);
            end else if (cmd == CMD_REMOVE) begin
                if (!busy[handle]) begin
                    push_event(ST_BAD, 0, '0, '0, 1);
                    return;
                end
                foreach (due_order[i])
                    if (due_order[i] == handle) begin
                        due_order.delete(i);
                        break;
                    end
                busy[handle] = 0;
                push_event(ST_REMOVED, 0, '0, '0, 1);
            end else if (cmd == CMD_TICK) begin
                now_ticks = now_ticks + 1;
                n = 0;
                while (due_order.size() > 0 && n < MAX_BURST
                       && due_at[due_order[0]] <= now_ticks) begin
                    free_slot = due_order.pop_front();
                    busy[free_slot] = 0;
                    push_event(ST_DISPATCH, free_slot, tag_of[free_slot], arg_of[free_slot], 0);
                    n++;
                end
                if (n > 0)
                    pending_events[pending_events.size() - 1].last = 1;
            end
        endfunction

        function void check_event(timer_event_t got);
            timer_event_t want;
            if (pending_events.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected transfer: status %0d slot %0d tag %h arg %h last %0d",
                             got.status, got.slot, got.tag, got.arg, got.last);
                return;
            end
            want = pending_events.pop_front();
            if (want !== got) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: exp status %0d slot %0d tag %h arg %h last %0d, got status %0d slot %0d tag %h arg %h last %0d",
                             want.status, want.slot, want.tag, want.arg, want.last,
                             got.status, got.slot, got.tag, got.arg, got.last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    dstq_in_if  in_ch();
    dstq_out_if out_ch();

    deadline_sorted_timer_queue i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    timer_scoreboard sb = new();
    int  burst_left;
    int  hold_cycles;
    bit  hold_request;

    always #5 clk = ~clk;

    initial
    begin
        clk            = 0;
        rst_n          = 0;
        in_ch.valid    = 0;
        in_ch.command  = CMD_ADD;
        in_ch.delay    = '0;
        in_ch.task_tag = '0;
        in_ch.task_arg = '0;
        in_ch.handle   = '0;
        out_ch.ready   = 0;
        hold_request   = 0;
        burst_left     = 0;
    end

    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: own stall pattern, plus one long hold-off on request
    initial
    begin
        int phase;
        timer_event_t got;
        phase       = 0;
        hold_cycles = 0;
        forever begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready) begin
                got.status = out_ch.status;
                got.slot   = out_ch.slot;
                got.tag    = out_ch.out_tag;
                got.arg    = out_ch.out_arg;
                got.last   = out_ch.last;
                sb.check_event(got);
            end
            if (hold_request && hold_cycles == 0)
                hold_cycles = 400;
            if (hold_cycles > 0) begin
                hold_cycles--;
                if (hold_cycles == 0)
                    hold_request = 0;
                out_ch.ready <= 0;
            end else if (!rst_n) begin
                out_ch.ready <= 0;
            end else begin
                phase = (phase + 1) % 96;
                if (phase < 24)
                    out_ch.ready <= $urandom_range(0, 1);
                else if (phase < 48)
                    out_ch.ready <= 1;
                else
                    out_ch.ready <= ($urandom_range(0, 7) != 0);
            end
        end
    end

    task automatic send_command(logic [1:0] cmd, logic [31:0] delay, logic [31:0] tag,
                                logic [31:0] arg, logic [5:0] handle);
        int gap;
        in_ch.valid    <= 1;
        in_ch.command  <= cmd;
        in_ch.delay    <= delay;
        in_ch.task_tag <= tag;
        in_ch.task_arg <= arg;
        in_ch.handle   <= handle;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_command(cmd, delay, tag, arg, handle);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = $urandom_range(1, 6);
            in_ch.valid <= 0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic add_task(logic [31:0] delay);
        send_command(CMD_ADD, delay, $urandom, $urandom, '0);
    endtask

    task automatic tick_once();
        send_command(CMD_TICK, $urandom, $urandom, $urandom, 6'($urandom));
    endtask

    function automatic logic [5:0] pick_handle();
        int live [$];
        foreach (sb.busy[i])
            if (sb.busy[i])
                live.push_back(i);
        if (live.size() > 0 && $urandom_range(0, 9) < 7)
            return 6'(live[$urandom_range(0, live.size() - 1)]);
        return 6'($urandom_range(0, SLOTS - 1));
    endfunction

    initial
    begin
        bit   filling;
        int   roll;
        logic [31:0] delay;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // directed: extremes, ties, bad handles, ignored command
        add_task(32'd0);
        send_command(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
        add_task(32'd2);
        add_task(32'd2);
        add_task(32'd1);
        send_command(CMD_ADD, 32'd3, 32'h0, 32'h0, 6'h0);
        tick_once();
        tick_once();
        tick_once();
        send_command(CMD_REMOVE, '0, '0, '0, 6'h3F);
        send_command(CMD_REMOVE, '0, '0, '0, 6'd5);
        send_command(CMD_REMOVE, '0, '0, '0, 6'd1);
        send_command(CMD_REMOVE, '0, '0, '0, 6'd1);
        send_command(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
        tick_once();
        tick_once();
        add_task(32'd5);
        add_task(32'd5);
        add_task(32'd5);
        repeat (4) tick_once();

        // random: alternating fill and drain phases; a hold-off during the first fill
        filling = 1;
        for (int k = 0; k < 410; k++) begin
            if (k % 100 == 0)
                filling = !filling || k == 0;
            if (k == 20)
                hold_request = 1;
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0)
                delay = $urandom;
            else
                delay = $urandom_range(0, 24);
            if (roll < (filling ? 85 : 35))
                add_task(delay);
            else if (roll < (filling ? 92 : 50))
                send_command(CMD_REMOVE, $urandom, $urandom, $urandom, pick_handle());
            else if (roll < 99)
                tick_once();
            else
                send_command(CMD_UNUSED, $urandom, $urandom, $urandom, 6'($urandom));
        end
        in_ch.valid <= 0;

        while (sb.pending_events.size() > 0 || hold_request)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.failures == 0 && sb.pending_events.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
